### design/hsl_to_rgb_converter_top_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef HSL_TO_RGB_CONVERTER_TOP_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

`define H2R_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("h2r assertion failed");

`define H2R_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("h2r assertion failed");

`else

`define H2R_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define H2R_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/h2r_pkg.sv
`default_nettype none

package h2r_pkg;

    localparam int FIELD_W = 13;
    localparam int BYTE_W  = 8;
    localparam int IN_BITS = 12;
    localparam logic [FIELD_W-1:0] IN_MAX = 13'd4096;

    localparam int NUM_CH   = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef struct packed {
        logic [FIELD_W-1:0] hue;
        logic [FIELD_W-1:0] saturation;
        logic [FIELD_W-1:0] lightness;
    } hsl_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } rgb_t;

    // Segment of the piecewise-linear hue ramp
    typedef enum logic [1:0] {
        RAMP_UP,
        RAMP_HIGH,
        RAMP_DOWN,
        RAMP_LOW
    } ramp_sel_t;

endpackage

`default_nettype wire

### design/h2r_stream_if.sv
`default_nettype none

interface h2r_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

`default_nettype wire

### design/hsl_to_rgb_converter_top.sv
// HSL to RGB pixel converter, four-stage pipeline.
// An accepted item moves through the stage 1, 2, 3 and 4 registers; rgb shows the stage 4 register.
// Throughput: one item per cycle; the whole pipeline freezes while rgb is stalled.
// Stages: convert and lightness*saturation, q/p and ramp gain, ramp multiply, scale to 8 bits.
// Reset: asynchronous active-low rst_n clears the stage valid bits only.
`default_nettype none
`include "hsl_to_rgb_converter_top_macros.svh"

module hsl_to_rgb_converter_top #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    h2r_stream_if.sink        hsl,
    h2r_stream_if.source      rgb
);

    localparam int FW  = FRAC_BITS + 1;       // fraction that can hold 1.0
    localparam int PW  = FRAC_BITS + 3;       // holds values below eight times ONE
    localparam int LSW = 2 * FRAC_BITS + 2;   // lightness * saturation
    localparam int PRW = 2 * FRAC_BITS + 4;   // ramp product
    localparam int XW  = FRAC_BITS + h2r_pkg::FIELD_W;

    localparam logic [PW-1:0] ONE      = PW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] HALF     = ONE >> 1;
    localparam logic [PW-1:0] TWO      = ONE << 1;
    localparam logic [PW-1:0] THREE    = ONE + TWO;
    localparam logic [PW-1:0] ONE_HALF = ONE + HALF;

    function automatic logic [h2r_pkg::BYTE_W-1:0] to_byte(input logic [PW-1:0] v);
        logic [PW+7:0] sc;
        logic [PW+7:0] sh;
        sc = ({8'd0, v} << 8) - {8'd0, v};
        sh = sc >> FRAC_BITS;
        return (|sh[PW+7:8]) ? 8'hFF : sh[7:0];
    endfunction

    logic en;

    // Stage 1
    logic           v1_reg;
    logic           grey1_reg, grey1_next;
    logic [FW-1:0]  lit1_reg, lit1_next;
    logic [FW-1:0]  sat1_reg, sat1_next;
    logic [LSW-1:0] ls1_reg, ls1_next;
    logic [PW-1:0]  pos1_reg [h2r_pkg::NUM_CH];
    logic [PW-1:0]  pos1_next [h2r_pkg::NUM_CH];

    // Stage 2
    logic                      v2_reg;
    logic                      grey2_reg, grey2_next;
    logic [h2r_pkg::BYTE_W-1:0] gbyte2_reg, gbyte2_next;
    logic [PW-1:0]             q2_reg, q2_next;
    logic [PW-1:0]             p2_reg, p2_next;
    logic [PW-1:0]             d2_reg, d2_next;
    h2r_pkg::ramp_sel_t        sel2_reg [h2r_pkg::NUM_CH];
    h2r_pkg::ramp_sel_t        sel2_next [h2r_pkg::NUM_CH];
    logic [FW-1:0]             m2_reg [h2r_pkg::NUM_CH];
    logic [FW-1:0]             m2_next [h2r_pkg::NUM_CH];

    // Stage 3
    logic                      v3_reg;
    logic                      grey3_reg;
    logic [h2r_pkg::BYTE_W-1:0] gbyte3_reg;
    logic [PW-1:0]             q3_reg;
    logic [PW-1:0]             p3_reg;
    h2r_pkg::ramp_sel_t        sel3_reg [h2r_pkg::NUM_CH];
    logic [PRW-1:0]            prod3_reg [h2r_pkg::NUM_CH];
    logic [PRW-1:0]            prod3_next [h2r_pkg::NUM_CH];

    // Stage 4 (output register)
    logic          v4_reg;
    h2r_pkg::rgb_t rgb4_reg, rgb4_next;

    // Advance the whole pipeline unless a result is held by the sink
    assign en        = !v4_reg || rgb.ready;
    assign hsl.ready = en;
    assign rgb.valid = v4_reg;
    assign rgb.payload = rgb4_reg;

    // ---------------- Stage 1: saturate, convert, multiply, hue positions
    always_comb
    begin
        logic [h2r_pkg::FIELD_W-1:0] hue_sat;
        logic [h2r_pkg::FIELD_W-1:0] sat_sat;
        logic [h2r_pkg::FIELD_W-1:0] lit_sat;
        logic [XW-1:0]               hue_w;
        logic [XW-1:0]               sat_w;
        logic [XW-1:0]               lit_w;
        logic [FW-1:0]               hue_i;
        logic [PW-1:0]               h3;
        logic [PW-1:0]               red_pos;

        hue_sat = (hsl.payload.hue > h2r_pkg::IN_MAX) ? h2r_pkg::IN_MAX : hsl.payload.hue;
        sat_sat = (hsl.payload.saturation > h2r_pkg::IN_MAX) ?
                  h2r_pkg::IN_MAX : hsl.payload.saturation;
        lit_sat = (hsl.payload.lightness > h2r_pkg::IN_MAX) ?
                  h2r_pkg::IN_MAX : hsl.payload.lightness;

        hue_w = ({{FRAC_BITS{1'b0}}, hue_sat} << FRAC_BITS) >> h2r_pkg::IN_BITS;
        sat_w = ({{FRAC_BITS{1'b0}}, sat_sat} << FRAC_BITS) >> h2r_pkg::IN_BITS;
        lit_w = ({{FRAC_BITS{1'b0}}, lit_sat} << FRAC_BITS) >> h2r_pkg::IN_BITS;

        hue_i     = hue_w[FW-1:0];
        sat1_next = sat_w[FW-1:0];
        lit1_next = lit_w[FW-1:0];
        ls1_next  = lit1_next * sat1_next;
        grey1_next = (hsl.payload.saturation == '0);

        // Ramp position is 3*hue in units of ONE; one turn is THREE
        h3 = {2'b00, hue_i} + {1'b0, hue_i, 1'b0};

        red_pos = h3 + ONE;
        pos1_next[h2r_pkg::CH_RED]   = (red_pos > THREE) ? red_pos - THREE : red_pos;
        pos1_next[h2r_pkg::CH_GREEN] = h3;
        pos1_next[h2r_pkg::CH_BLUE]  = (h3 < ONE) ? h3 + TWO : h3 - ONE;
    end

    // ---------------- Stage 2: q, p and per-channel ramp segment and gain
    always_comb
    begin
        logic [LSW-1:0] ls_w;
        logic [PW-1:0]  lsh;
        logic [PW-1:0]  lx;
        logic [PW-1:0]  sx;
        logic [PW-1:0]  l2;
        logic [PW-1:0]  qa;
        logic [PW-1:0]  pa;
        logic [PW-1:0]  t;
        logic [PW-1:0]  mw;

        ls_w = ls1_reg >> FRAC_BITS;
        lsh  = ls_w[PW-1:0];
        lx   = {2'b00, lit1_reg};
        sx   = {2'b00, sat1_reg};
        l2   = lx << 1;

        if (l2 < ONE)
        begin
            qa = lx + lsh;
        end
        else
        begin
            qa = lx + sx - lsh;
        end
        if (qa > l2)
        begin
            qa = l2;
        end
        pa = l2 - qa;
        if (qa < pa)
        begin
            qa = pa;
        end

        q2_next     = qa;
        p2_next     = pa;
        d2_next     = qa - pa;
        grey2_next  = grey1_reg;
        gbyte2_next = to_byte(lx);

        for (int c = 0; c < h2r_pkg::NUM_CH; c++)
        begin
            t = pos1_reg[c];
            if (t < HALF)
            begin
                sel2_next[c] = h2r_pkg::RAMP_UP;
                mw = t << 1;
            end
            else if (t < ONE_HALF)
            begin
                sel2_next[c] = h2r_pkg::RAMP_HIGH;
                mw = '0;
            end
            else if (t < TWO)
            begin
                sel2_next[c] = h2r_pkg::RAMP_DOWN;
                mw = (TWO - t) << 1;
            end
            else
            begin
                sel2_next[c] = h2r_pkg::RAMP_LOW;
                mw = '0;
            end
            m2_next[c] = mw[FW-1:0];
        end
    end

    // ---------------- Stage 3: ramp multiply
    always_comb
    begin
        for (int c = 0; c < h2r_pkg::NUM_CH; c++)
        begin
            prod3_next[c] = d2_reg * m2_reg[c];
        end
    end

    // ---------------- Stage 4: ramp value, scale to 8 bits, grey bypass
    always_comb
    begin
        logic [PRW-1:0]             pr;
        logic [PW-1:0]              v;
        logic [h2r_pkg::BYTE_W-1:0] bytes [h2r_pkg::NUM_CH];

        for (int c = 0; c < h2r_pkg::NUM_CH; c++)
        begin
            pr = prod3_reg[c] >> FRAC_BITS;
            case (sel3_reg[c]) inside
                h2r_pkg::RAMP_UP, h2r_pkg::RAMP_DOWN: v = p3_reg + pr[PW-1:0];
                h2r_pkg::RAMP_HIGH:                   v = q3_reg;
                default:                              v = p3_reg;
            endcase
            bytes[c] = to_byte(v);
        end

        if (grey3_reg)
        begin
            rgb4_next.red   = gbyte3_reg;
            rgb4_next.green = gbyte3_reg;
            rgb4_next.blue  = gbyte3_reg;
        end
        else
        begin
            rgb4_next.red   = bytes[h2r_pkg::CH_RED];
            rgb4_next.green = bytes[h2r_pkg::CH_GREEN];
            rgb4_next.blue  = bytes[h2r_pkg::CH_BLUE];
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= hsl.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Payload registers: hold on stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grey1_reg  <= grey1_next;
            lit1_reg   <= lit1_next;
            sat1_reg   <= sat1_next;
            ls1_reg    <= ls1_next;

            grey2_reg  <= grey2_next;
            gbyte2_reg <= gbyte2_next;
            q2_reg     <= q2_next;
            p2_reg     <= p2_next;
            d2_reg     <= d2_next;

            grey3_reg  <= grey2_reg;
            gbyte3_reg <= gbyte2_reg;
            q3_reg     <= q2_reg;
            p3_reg     <= p2_reg;

            rgb4_reg   <= rgb4_next;

            for (int c = 0; c < h2r_pkg::NUM_CH; c++)
            begin
                pos1_reg[c]  <= pos1_next[c];
                sel2_reg[c]  <= sel2_next[c];
                m2_reg[c]    <= m2_next[c];
                sel3_reg[c]  <= sel2_reg[c];
                prod3_reg[c] <= prod3_next[c];
            end
        end
    end

    `H2R_ASSERT_IMP(a_q_not_below_p, clk, rst_n, v2_reg, q2_reg >= p2_reg)
    `H2R_ASSERT_IMP(a_ramp_gain_max, clk, rst_n, v2_reg,
        (m2_reg[h2r_pkg::CH_RED] <= ONE) && (m2_reg[h2r_pkg::CH_GREEN] <= ONE) &&
        (m2_reg[h2r_pkg::CH_BLUE] <= ONE))
    `H2R_ASSERT_NXT(a_grey_equal, clk, rst_n, v3_reg && grey3_reg && en,
        (rgb.payload.red == rgb.payload.green) && (rgb.payload.green == rgb.payload.blue))
    `H2R_ASSERT_NXT(a_stall_holds_s3, clk, rst_n, !en, $stable(v3_reg))

endmodule

`default_nettype wire
